// ===== hw/rtl/chfm_pkg.sv =====
// ----------------------------------------------------------------------------
// chfm_pkg
// Shared constants, types and the arctangent table for the compass heading core.
// ----------------------------------------------------------------------------
package chfm_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int TABLE_LEN     = 24;
  localparam int NCS = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  // stages before CORDIC: offset, cross-multiply, half-plane fold, lzc, normalize
  localparam int PRE_STAGES = 5;
  // total register stages: prelim + CORDIC + scale multiply + output
  localparam int NST = PRE_STAGES + NCS + 2;

  localparam int XW = 18;  // offset-corrected axis
  localparam int PW = 29;  // cross-multiplied axis
  localparam int CW = 33;  // CORDIC datapath
  localparam int ZW = 32;  // binary angle, full turn = 2^32
  localparam int HW = 15;  // heading
  localparam int KW = 5;   // normalize shift amount

  localparam int unsigned FULL_DEG64 = 23040;

  typedef logic signed [XW-1:0] axis_t;
  typedef logic signed [PW-1:0] prod_t;
  typedef logic signed [CW-1:0] cord_t;
  typedef logic        [ZW-1:0] ang_t;
  typedef logic        [HW-1:0] head_t;

  typedef enum logic [2:0] {
    REG_OFFSET_X     = 3'd0,
    REG_OFFSET_Y     = 3'd1,
    REG_SCALE_X      = 3'd2,
    REG_SCALE_Y      = 3'd3,
    REG_HEADING_TRIM = 3'd4
  } reg_idx_t;

  localparam logic signed [12:0] OFFSET_X_RST = -13'sd179;
  localparam logic signed [12:0] OFFSET_Y_RST = -13'sd1812;
  localparam logic [11:0]        SCALE_X_RST  = 12'd301;
  localparam logic [11:0]        SCALE_Y_RST  = 12'd257;
  localparam logic [14:0]        TRIM_RST     = 15'd0;

  // atan(2^-i) as a binary angle
  localparam ang_t ATAN_TAB [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

// ===== hw/rtl/compass_heading_from_magnetometer_core.sv =====
// ----------------------------------------------------------------------------
// compass_heading_from_magnetometer_core
// Hard/soft-iron corrected X/Y magnetometer sample to compass heading.
// ----------------------------------------------------------------------------
// Takes one X/Y sample per cycle while in_tready is high and returns heading
// in 1/64 degree steps (0..23039). Each sample passes through chfm_pkg::NST
// register stages (CORDIC_STAGES + 7) from
// acceptance to out_tvalid: offset subtract, soft-iron cross-multiply,
// half-plane fold, leading-zero count, normalize shift, one stage per CORDIC
// rotation, the degree scaling multiply and the trim/wrap output register.
// Valid bits travel with the data and each stage advances independently, so
// bubbles are squeezed out under backpressure. When both corrected axes are
// zero the heading is 0 and the trim is not applied. Scale registers written
// as 0 act as 1. Configuration writes must only happen while no sample is in
// flight.
module compass_heading_from_magnetometer_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] raw_x, [31:16] raw_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [14:0] heading, [15] driven low
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [14:0] cfg_wdata
);

  localparam int NST = chfm_pkg::NST;
  localparam int NCS = chfm_pkg::NCS;
  localparam int SN  = chfm_pkg::PRE_STAGES;  // index of first CORDIC stage
  localparam int SM  = SN + NCS;              // scale multiply stage
  localparam int SO  = SM + 1;                // output stage

  // configuration registers
  logic signed [12:0] offset_x_r, offset_y_r;
  logic [11:0]        scale_x_r, scale_y_r;
  logic [14:0]        trim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_x_r <= chfm_pkg::OFFSET_X_RST;
      offset_y_r <= chfm_pkg::OFFSET_Y_RST;
      scale_x_r  <= chfm_pkg::SCALE_X_RST;
      scale_y_r  <= chfm_pkg::SCALE_Y_RST;
      trim_r     <= chfm_pkg::TRIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        chfm_pkg::REG_OFFSET_X:     offset_x_r <= cfg_wdata[12:0];
        chfm_pkg::REG_OFFSET_Y:     offset_y_r <= cfg_wdata[12:0];
        chfm_pkg::REG_SCALE_X:      scale_x_r  <= cfg_wdata[11:0];
        chfm_pkg::REG_SCALE_Y:      scale_y_r  <= cfg_wdata[11:0];
        chfm_pkg::REG_HEADING_TRIM: trim_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld_r;
  logic [NST-1:0] en;
  logic [NST-2:0] zf_r;  // both corrected axes zero

  always_comb begin
    en[NST-1] = !vld_r[NST-1] || out_tready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !vld_r[i] || en[i+1];
    end
  end

  assign in_tready  = en[0];
  assign out_tvalid = vld_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_tvalid;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) vld_r[i] <= vld_r[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 0: hard-iron offset
  // ---------------------------------------------------------------------------
  chfm_pkg::axis_t xc_r, yc_r;
  chfm_pkg::axis_t xc_nxt, yc_nxt;

  always_comb begin
    xc_nxt = chfm_pkg::XW'($signed(in_tdata[15:0])) - chfm_pkg::XW'(offset_x_r);
    yc_nxt = chfm_pkg::XW'($signed(in_tdata[31:16])) - chfm_pkg::XW'(offset_y_r);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xc_r    <= xc_nxt;
      yc_r    <= yc_nxt;
      zf_r[0] <= (xc_nxt == '0) && (yc_nxt == '0);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: soft-iron cross-multiply, A = xc*sy, B = -yc*sx
  // ---------------------------------------------------------------------------
  logic [11:0]        sx_eff, sy_eff;
  logic signed [30:0] pa, pb;
  chfm_pkg::prod_t    pa_r, pb_r;

  assign sx_eff = (scale_x_r == '0) ? 12'd1 : scale_x_r;
  assign sy_eff = (scale_y_r == '0) ? 12'd1 : scale_y_r;
  assign pa     = xc_r * $signed({1'b0, sy_eff});
  assign pb     = yc_r * $signed({1'b0, sx_eff});

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pa_r    <= pa[chfm_pkg::PW-1:0];
      pb_r    <= -pb[chfm_pkg::PW-1:0];
      zf_r[1] <= zf_r[0];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: fold left half-plane into the right, seed angle with a half turn
  // ---------------------------------------------------------------------------
  chfm_pkg::prod_t fa_r, fb_r;
  chfm_pkg::ang_t  fz_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (pb_r[chfm_pkg::PW-1]) begin
        fa_r <= -pa_r;
        fb_r <= -pb_r;
        fz_r <= 32'h8000_0000;
      end else begin
        fa_r <= pa_r;
        fb_r <= pb_r;
        fz_r <= '0;
      end
      zf_r[2] <= zf_r[1];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 3: leading-one search for normalization to 2^28
  // ---------------------------------------------------------------------------
  chfm_pkg::prod_t       la_r, lb_r;
  chfm_pkg::ang_t        lz_r;
  logic [chfm_pkg::KW-1:0] k_r, k_nxt;
  logic [chfm_pkg::PW-1:0] mag_or;
  logic [chfm_pkg::KW-1:0] msb;

  always_comb begin
    mag_or = (fa_r[chfm_pkg::PW-1] ? -fa_r : fa_r) | (fb_r[chfm_pkg::PW-1] ? -fb_r : fb_r);
    msb    = '0;
    for (int i = 0; i < chfm_pkg::PW; i++) begin
      if (mag_or[i]) msb = chfm_pkg::KW'(i);
    end
    k_nxt = chfm_pkg::KW'(chfm_pkg::PW - 1) - msb;
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      la_r    <= fa_r;
      lb_r    <= fb_r;
      lz_r    <= fz_r;
      k_r     <= k_nxt;
      zf_r[3] <= zf_r[2];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: normalize shift, then one register stage per CORDIC rotation
  // ---------------------------------------------------------------------------
  chfm_pkg::cord_t ca_r [NCS+1];
  chfm_pkg::cord_t cb_r [NCS+1];
  chfm_pkg::ang_t  cz_r [NCS+1];

  always_ff @(posedge clk) begin
    if (en[SN-1]) begin
      ca_r[0]    <= chfm_pkg::CW'(la_r) <<< k_r;
      cb_r[0]    <= chfm_pkg::CW'(lb_r) <<< k_r;
      cz_r[0]    <= lz_r;
      zf_r[SN-1] <= zf_r[SN-2];
    end
  end

  for (genvar g = 0; g < NCS; g++) begin : g_cordic
    chfm_pkg::cord_t da, db;
    assign da = ca_r[g] >>> g;
    assign db = cb_r[g] >>> g;

    always_ff @(posedge clk) begin
      if (en[SN+g]) begin
        if (!ca_r[g][chfm_pkg::CW-1]) begin
          cb_r[g+1] <= cb_r[g] + da;
          ca_r[g+1] <= ca_r[g] - db;
          cz_r[g+1] <= cz_r[g] + chfm_pkg::ATAN_TAB[g];
        end else begin
          cb_r[g+1] <= cb_r[g] - da;
          ca_r[g+1] <= ca_r[g] + db;
          cz_r[g+1] <= cz_r[g] - chfm_pkg::ATAN_TAB[g];
        end
        zf_r[SN+g] <= zf_r[SN+g-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // angle to 1/64 degree, rounded half up
  // ---------------------------------------------------------------------------
  logic [46:0]     deg_prod;
  chfm_pkg::head_t h_r;

  assign deg_prod = 47'(cz_r[NCS]) * 47'(chfm_pkg::FULL_DEG64) + 47'(64'h8000_0000);

  always_ff @(posedge clk) begin
    if (en[SM]) begin
      h_r      <= deg_prod[46:32];
      zf_r[SM] <= zf_r[SM-1];
    end
  end

  // ---------------------------------------------------------------------------
  // trim and wrap into [0, 23040)
  // ---------------------------------------------------------------------------
  chfm_pkg::head_t h_wrap;
  logic [15:0]     hsum;
  chfm_pkg::head_t heading_nxt, heading_r;

  always_comb begin
    h_wrap = (h_r >= chfm_pkg::HW'(chfm_pkg::FULL_DEG64)) ? '0 : h_r;
    hsum   = {1'b0, h_wrap} + {1'b0, trim_r};
    if (hsum >= 16'(2 * chfm_pkg::FULL_DEG64)) begin
      hsum = hsum - 16'(2 * chfm_pkg::FULL_DEG64);
    end else if (hsum >= 16'(chfm_pkg::FULL_DEG64)) begin
      hsum = hsum - 16'(chfm_pkg::FULL_DEG64);
    end
    heading_nxt = zf_r[SM] ? '0 : hsum[chfm_pkg::HW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[SO]) heading_r <= heading_nxt;
  end

  assign out_tdata = {1'b0, heading_r};

endmodule
